@@ src/deque_with_value_search_defines.svh @@
// assertion macros shared by the deque block
`ifndef DEQUE_WITH_VALUE_SEARCH_DEFINES_SVH
`define DEQUE_WITH_VALUE_SEARCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DQVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DQVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dqvs_pkg.sv @@
package dqvs_pkg;

   // stored word and field types
   typedef logic signed [31:0] word_type;
   typedef logic [2:0]         req_code_type;
   typedef logic [1:0]         status_type;

   // request codes
   localparam req_code_type OP_PUSH_FRONT = 3'd0;
   localparam req_code_type OP_PUSH_BACK  = 3'd1;
   localparam req_code_type OP_POP_FRONT  = 3'd2;
   localparam req_code_type OP_POP_BACK   = 3'd3;
   localparam req_code_type OP_CONTAINS   = 3'd4;
   localparam req_code_type OP_REMOVE     = 3'd5;

   // status codes
   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_UNDERFLOW = 2'd1;
   localparam status_type STAT_OVERFLOW  = 2'd2;

endpackage

@@ src/dqvs_ram.sv @@
module dqvs_ram #(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  dqvs_pkg::word_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output dqvs_pkg::word_type  rd_data
);

   dqvs_pkg::word_type mem [DEPTH];
   dqvs_pkg::word_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // single registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/deque_with_value_search.sv @@
// Bounded double-ended queue of signed 32-bit values kept in a ring RAM of DEPTH entries.
// One request is taken at a time; req_stall stays high from acceptance until the result
// has been placed in the output register, and the next request can be taken in the
// cycle after that. A result left waiting on rsp_stall does not keep the next request
// out, but that request holds in its result step until the output register is free.
// Push, pop and unused codes pass through execute, front read, back read and result
// steps. Contains and remove walk the entries from the front with one comparator fed
// by the single RAM read port, one entry per cycle, and remove then closes the gap one
// entry per cycle on the same port. The RAM needs no clearing pass after reset.
module deque_with_value_search #(
   parameter int DEPTH = 16,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dqvs_pkg::req_code_type    req_type,
   input  logic signed [31:0]        req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_front_value,
   output logic signed [31:0]        rsp_back_value,
   output logic [CW-1:0]             rsp_entry_count,
   output logic                      rsp_is_empty,
   output logic                      rsp_found,
   output dqvs_pkg::status_type      rsp_status
);

   localparam int IW = $clog2(DEPTH);
   localparam int SW = IW + 1;
   localparam logic [CW-1:0] FULL    = CW'(DEPTH);
   localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_EXEC    = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_SHIFT   = 3'd3;
   localparam logic [2:0] ST_FETCH_F = 3'd4;
   localparam logic [2:0] ST_FETCH_B = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   // ring index helpers
   function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
      slot_inc = (s == LAST) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
      slot_dec = (s == '0) ? LAST : s - 1'b1;
   endfunction

   function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      slot_add = sum[IW-1:0];
   endfunction

   // control registers
   logic [2:0]              state_ff, state_in;
   logic [IW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // working registers
   dqvs_pkg::req_code_type  op_ff, op_in;
   dqvs_pkg::word_type      val_ff, val_in;
   logic [IW-1:0]           cur_slot_ff, cur_slot_in;
   logic [CW-1:0]           cur_off_ff, cur_off_in;
   logic [IW-1:0]           rd_slot_ff, rd_slot_in;
   logic                    found_ff, found_in;
   dqvs_pkg::status_type    status_ff, status_in;
   dqvs_pkg::word_type      front_ff, front_in;

   // result registers
   dqvs_pkg::word_type      rsp_front_ff, rsp_front_in;
   dqvs_pkg::word_type      rsp_back_ff, rsp_back_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_found_ff, rsp_found_in;
   dqvs_pkg::status_type    rsp_status_ff, rsp_status_in;

   // ram port
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   dqvs_pkg::word_type      wr_data;
   logic                    rd_en;
   logic [IW-1:0]           rd_addr;
   dqvs_pkg::word_type      rd_data;

   logic [CW-1:0]           off_next;

   assign off_next = cur_off_ff + 1'b1;

   dqvs_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      cur_slot_in   = cur_slot_ff;
      cur_off_in    = cur_off_ff;
      rd_slot_in    = rd_slot_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      front_in      = front_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_slot_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = rd_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_type;
               val_in    = req_item_value;
               found_in  = 1'b0;
               status_in = dqvs_pkg::STAT_OK;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FETCH_F;
            unique case (op_ff)
               dqvs_pkg::OP_PUSH_FRONT: begin
                  if (count_ff == FULL) begin
                     status_in = dqvs_pkg::STAT_OVERFLOW;
                  end else begin
                     head_in  = slot_dec(head_ff);
                     wr_en    = 1'b1;
                     wr_addr  = slot_dec(head_ff);
                     wr_data  = val_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               dqvs_pkg::OP_PUSH_BACK: begin
                  if (count_ff == FULL) begin
                     status_in = dqvs_pkg::STAT_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot_add(head_ff, count_ff);
                     wr_data  = val_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               dqvs_pkg::OP_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status_in = dqvs_pkg::STAT_UNDERFLOW;
                  end else begin
                     head_in  = slot_inc(head_ff);
                     count_in = count_ff - 1'b1;
                  end
               end
               dqvs_pkg::OP_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = dqvs_pkg::STAT_UNDERFLOW;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
               dqvs_pkg::OP_CONTAINS, dqvs_pkg::OP_REMOVE: begin
                  if (count_ff == '0) begin
                     if (op_ff == dqvs_pkg::OP_REMOVE) begin
                        status_in = dqvs_pkg::STAT_UNDERFLOW;
                     end
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = head_ff;
                     rd_slot_in  = head_ff;
                     cur_slot_in = head_ff;
                     cur_off_in  = '0;
                     state_in    = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         // compare the entry just read, read the next one ahead
         ST_SCAN: begin
            rd_en      = 1'b1;
            rd_addr    = slot_inc(rd_slot_ff);
            rd_slot_in = slot_inc(rd_slot_ff);
            if (rd_data == val_ff) begin
               found_in = 1'b1;
               state_in = (op_ff == dqvs_pkg::OP_REMOVE) ? ST_SHIFT : ST_FETCH_F;
            end else if (off_next == count_ff) begin
               state_in = ST_FETCH_F;
            end else begin
               cur_slot_in = slot_inc(cur_slot_ff);
               cur_off_in  = off_next;
            end
         end
         // move each later entry one place toward the front
         ST_SHIFT: begin
            if (off_next == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_FETCH_F;
            end else begin
               wr_en       = 1'b1;
               wr_addr     = cur_slot_ff;
               wr_data     = rd_data;
               cur_slot_in = rd_slot_ff;
               cur_off_in  = off_next;
               rd_en       = 1'b1;
               rd_addr     = slot_inc(rd_slot_ff);
               rd_slot_in  = slot_inc(rd_slot_ff);
            end
         end
         ST_FETCH_F: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = ST_FETCH_B;
         end
         ST_FETCH_B: begin
            front_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = slot_add(head_ff, count_ff - 1'b1);
            state_in = ST_DONE;
         end
         // load the result once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_front_in  = (count_ff == '0) ? '0 : front_ff;
               rsp_back_in   = (count_ff == '0) ? '0 : rd_data;
               rsp_count_in  = count_ff;
               rsp_empty_in  = (count_ff == '0);
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      cur_slot_ff   <= cur_slot_in;
      cur_off_ff    <= cur_off_in;
      rd_slot_ff    <= rd_slot_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      front_ff      <= front_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

   // checks
`include "deque_with_value_search_defines.svh"

   `DQVS_ASSERT_NEXT(a_accept_starts_exec, clock, reset, req_valid && !req_stall, state_ff == ST_EXEC, "accepted transaction did not start execution")
   `DQVS_ASSERT_NOW(a_result_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result raised outside the result state")
   `DQVS_ASSERT_NOW(a_overflow_when_full, clock, reset, rsp_valid_ff && (rsp_status_ff == dqvs_pkg::STAT_OVERFLOW), rsp_count_ff == FULL, "overflow reported on a queue that is not full")
   `DQVS_ASSERT_NOW(a_shift_after_match, clock, reset, state_ff == ST_SHIFT, found_ff && (op_ff == dqvs_pkg::OP_REMOVE) && (off_next <= count_ff), "gap close without a matching remove")

endmodule
